// ===== sv/sau_pkg.sv =====
// Shared types and constants of the stack arithmetic unit.
package sau_pkg;

  localparam int DataWidth  = 32;
  localparam int StackDepth = 64;
  localparam int AddrWidth  = $clog2(StackDepth);
  localparam int CountWidth = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    OpNop  = 3'd0,
    OpPush = 3'd1,
    OpAdd  = 3'd2,
    OpSub  = 3'd3,
    OpMul  = 3'd4,
    OpDiv  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StShort   = 3'd1,
    StDivZero = 3'd2,
    StFull    = 3'd3,
    StHalted  = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]                  op;
    logic signed [DataWidth-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [2:0]                  status;
    logic signed [DataWidth-1:0] top_value;
    logic [CountWidth-1:0]       depth_now;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       push;
    logic       alu_capture;
    logic       div_start;
    logic       commit;
    logic       status_load;
    logic [2:0] status;
    logic       set_halt;
    logic [2:0] op;
  } cmd_t;

  // Conditions reported by the datapath to the controller.
  typedef struct packed {
    logic halted;
    logic short_stack;
    logic full;
    logic top_zero;
    logic div_done;
  } stat_t;

endpackage

// ===== sv/sau_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sau_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sau_pkg::DataWidth-1:0]  dividend_i,
  input  logic [sau_pkg::DataWidth-1:0]  divisor_i,
  output logic                           done_o,
  output logic [sau_pkg::DataWidth-1:0]  quotient_o
);

  localparam int W     = sau_pkg::DataWidth;
  localparam int CntW  = $clog2(W + 1);

  logic            running_q;
  logic [CntW-1:0] cnt_q;
  logic            neg_q;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q;
  logic [W:0]      trial;
  logic [W-1:0]    mag_a, mag_b;

  assign mag_a = dividend_i[W-1] ? (~dividend_i + W'(1)) : dividend_i;
  assign mag_b = divisor_i[W-1]  ? (~divisor_i + W'(1))  : divisor_i;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

  always_comb begin
    if (!trial[W]) begin
      rem_d = trial[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b1};
    end else begin
      rem_d = {rem_q[W-2:0], quo_q[W-1]};
      quo_d = {quo_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      cnt_q     <= '0;
    end else if (start_i) begin
      running_q <= 1'b1;
      cnt_q     <= CntW'(W);
    end else if (running_q) begin
      if (cnt_q == '0) begin
        running_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= mag_a;
      dvs_q <= mag_b;
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
    end else if (running_q && (cnt_q != '0)) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = running_q && (cnt_q == '0);
  assign quotient_o = neg_q ? (~quo_q + W'(1)) : quo_q;

endmodule

// ===== sv/sau_datapath.sv =====
// Stack storage, cached top, ALU, divider and result registers.
module sau_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sau_pkg::cmd_t                          cmd_i,
  input  logic signed [sau_pkg::DataWidth-1:0]   push_value_i,
  output sau_pkg::stat_t                         stat_o,
  output sau_pkg::rsp_t                          rsp_o
);

  localparam int W  = sau_pkg::DataWidth;
  localparam int AW = sau_pkg::AddrWidth;
  localparam int CW = sau_pkg::CountWidth;

  // The top entry lives in top_q; the memory holds the entries below it.
  logic [W-1:0]  mem_q [sau_pkg::StackDepth];
  logic [W-1:0]  rd_q;
  logic [W-1:0]  top_q;
  logic [W-1:0]  val_q;
  logic [W-1:0]  res_q, res_d;
  logic [CW-1:0] count_q;
  logic          halted_q;
  logic [2:0]    status_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic          div_done;
  logic [W-1:0]  quotient;

  assign rd_addr = count_q[AW-1:0] - AW'(2);
  assign wr_addr = count_q[AW-1:0] - AW'(1);
  assign wr_en   = cmd_i.push && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= top_q;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    case (cmd_i.op)
      sau_pkg::OpSub: res_d = rd_q - top_q;
      sau_pkg::OpMul: res_d = rd_q * top_q;
      default:        res_d = rd_q + top_q;
    endcase
  end

  sau_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rd_q),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      val_q <= push_value_i;
    end
    if (cmd_i.alu_capture) begin
      res_q <= res_d;
    end else if (div_done) begin
      res_q <= quotient;
    end
    if (cmd_i.push) begin
      top_q <= val_q;
    end else if (cmd_i.commit) begin
      top_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      halted_q <= 1'b0;
      status_q <= sau_pkg::StOk;
    end else begin
      if (cmd_i.push) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.commit) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.set_halt) begin
        halted_q <= 1'b1;
      end
      if (cmd_i.status_load) begin
        status_q <= cmd_i.status;
      end
    end
  end

  assign stat_o.halted      = halted_q;
  assign stat_o.short_stack = count_q < CW'(2);
  assign stat_o.full        = count_q == CW'(sau_pkg::StackDepth);
  assign stat_o.top_zero    = top_q == '0;
  assign stat_o.div_done    = div_done;

  assign rsp_o.status    = status_q;
  assign rsp_o.top_value = (count_q == '0) ? '0 : top_q;
  assign rsp_o.depth_now = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(sau_pkg::StackDepth))
    else $error("stack count beyond depth");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(halted_q))
    else $error("halted flag cleared without reset");

  a_commit_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> count_q >= CW'(2))
    else $error("binary operation committed on a short stack");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> count_q < CW'(sau_pkg::StackDepth))
    else $error("push on a full stack");

endmodule

// ===== sv/sau_controller.sv =====
// Control state machine: checks each request and sequences the datapath.
module sau_controller (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2:0]      op_i,
  input  sau_pkg::stat_t  stat_i,
  output sau_pkg::cmd_t   cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  typedef enum logic [2:0] {
    Idle,
    Check,
    Divide,
    Commit,
    Resp
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] op_q;
  logic       busy_q, done_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = op_q;
    cmd_o.status = sau_pkg::StOk;
    state_d      = state_q;
    unique case (state_q)
      Idle: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = Check;
        end
      end
      Check: begin
        cmd_o.status_load = 1'b1;
        state_d           = Resp;
        if (stat_i.halted) begin
          cmd_o.status = sau_pkg::StHalted;
        end else begin
          case (op_q) inside
            sau_pkg::OpPush: begin
              if (stat_i.full) begin
                cmd_o.status   = sau_pkg::StFull;
                cmd_o.set_halt = 1'b1;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            sau_pkg::OpAdd, sau_pkg::OpSub, sau_pkg::OpMul, sau_pkg::OpDiv: begin
              if (stat_i.short_stack) begin
                cmd_o.status   = sau_pkg::StShort;
                cmd_o.set_halt = 1'b1;
              end else if (op_q == sau_pkg::OpDiv) begin
                if (stat_i.top_zero) begin
                  cmd_o.status   = sau_pkg::StDivZero;
                  cmd_o.set_halt = 1'b1;
                end else begin
                  cmd_o.div_start = 1'b1;
                  state_d         = Divide;
                end
              end else begin
                cmd_o.alu_capture = 1'b1;
                state_d           = Commit;
              end
            end
            default: begin
              // Nop and the unused codes leave the stack alone.
              cmd_o.status = sau_pkg::StOk;
            end
          endcase
        end
      end
      Divide: begin
        if (stat_i.div_done) begin
          state_d = Commit;
        end
      end
      Commit: begin
        cmd_o.commit = 1'b1;
        state_d      = Resp;
      end
      Resp: begin
        state_d = Idle;
      end
      default: begin
        state_d = Idle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      op_q    <= sau_pkg::OpNop;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= state_d != Idle;
      done_q  <= state_d == Resp;
      if (cmd_o.capture) begin
        op_q <= op_i;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> busy_q)
    else $error("result strobe while idle");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !cmd_o.capture)
    else $error("request captured while busy");

endmodule

// ===== sv/stack_arithmetic_unit.sv =====
// Top level of the stack arithmetic unit.
//
//   channel   ports                 handshake
//   request   req_i                 start high while busy low
//   result    rsp_o                 done_o high for one cycle
//
// Push, nop, errors and requests while halted pass from the check state to the
// response state; add, sub and mul pass through check, commit and response.
// Div runs the one-bit-per-cycle divider in a divide state between check and
// commit. busy drops at the edge that ends each result strobe, so a request is
// taken only once the previous result is given. Reset empties the stack and
// clears the halted state; the receiver cannot stall and results are never held.
module stack_arithmetic_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sau_pkg::req_t  req_i,
  output logic           done_o,
  output sau_pkg::rsp_t  rsp_o
);

  sau_pkg::cmd_t  cmd;
  sau_pkg::stat_t stat;

  sau_controller u_controller (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (req_i.op),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  sau_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .push_value_i (req_i.push_value),
    .stat_o       (stat),
    .rsp_o        (rsp_o)
  );

endmodule
